>>> rtl/core/sii_pkg.sv
// Shared types, constants and the operation sequence of the inertial integrator.
`default_nettype none

package sii_pkg;

	localparam int CORDIC_STEPS = 20;
	localparam int ITER_W       = 5;
	localparam int NUM_UOPS     = 34;
	localparam int PC_W         = 6;
	localparam int OPND_W       = 34;
	localparam int PROD_W       = 2 * OPND_W;
	localparam int SUM_W        = 72;
	localparam int VEL_W        = 40;
	localparam int POS_W        = 48;
	localparam int ANG_W        = 16;
	localparam int ACCEL_W      = 24;
	localparam int RATE_W       = 24;
	localparam int DT_W         = 24;
	localparam int SPLIT        = 20;
	localparam int CFG_IDX_W    = 2;
	localparam int S_DATA_W     = 3 * ACCEL_W + 3 * ANG_W + 3 * RATE_W;
	localparam int M_DATA_W     = 3 * POS_W + 3 * VEL_W + 3 * ANG_W + 3 * RATE_W;

	localparam logic signed [OPND_W-1:0]  Q30_GAIN      = 34'sd652032874;
	localparam logic [DT_W-1:0]           TIME_STEP_RST = 24'd167772;
	localparam logic signed [ACCEL_W-1:0] GRAVITY_RST   = -24'sd642908;

	localparam logic signed [SUM_W-1:0] V_HI = SUM_W'((64'sd1 <<< (VEL_W - 1)) - 64'sd1);
	localparam logic signed [SUM_W-1:0] V_LO = -V_HI - SUM_W'(1);
	localparam logic signed [SUM_W-1:0] P_HI = SUM_W'((64'sd1 <<< (POS_W - 1)) - 64'sd1);
	localparam logic signed [SUM_W-1:0] P_LO = -P_HI - SUM_W'(1);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_TIME_STEP = 2'd0,
		REG_GRAVITY   = 2'd1
	} cfg_reg_t;

	typedef enum logic [4:0] {
		OP_SPH, OP_CPH, OP_STH, OP_CTH, OP_SPS, OP_CPS,
		OP_AX, OP_AY, OP_AZ, OP_T, OP_U,
		OP_R00, OP_R01, OP_R02, OP_R10, OP_R11, OP_R12, OP_R20, OP_R21, OP_R22,
		OP_AN, OP_AE, OP_AD, OP_GRAV, OP_DT, OP_ONE,
		OP_VNL, OP_VNH, OP_VEL, OP_VEH, OP_VDL, OP_VDH
	} opnd_t;

	typedef enum logic [4:0] {
		D_NONE, D_T, D_U,
		D_R00, D_R01, D_R02, D_R10, D_R11, D_R12, D_R20, D_R21, D_R22,
		D_AN, D_AE, D_AD, D_VN, D_VE, D_VD, D_PN, D_PE, D_PU
	} dst_t;

	typedef enum logic [1:0] {
		SH_0,
		SH_24,
		SH_30
	} shift_t;

	typedef struct packed {
		opnd_t  a;
		opnd_t  b;
		logic   acc_en;
		logic   hi_split;
		shift_t sh;
		logic   neg;
		logic   dacc;
		dst_t   dst;
	} uop_t;

	typedef struct packed {
		logic              load;
		logic              clear;
		logic              cordic_step;
		logic [ITER_W-1:0] iter;
		logic              mul;
		logic              acc;
		logic              wr;
		uop_t              uop;
	} dp_cmd_t;

	function automatic logic signed [OPND_W-1:0] cordic_arc(input logic [ITER_W-1:0] i);
		logic signed [OPND_W-1:0] v;
		unique case (i)
			5'd0:    v = 34'sd536870912;
			5'd1:    v = 34'sd316933406;
			5'd2:    v = 34'sd167458907;
			5'd3:    v = 34'sd85004756;
			5'd4:    v = 34'sd42667331;
			5'd5:    v = 34'sd21354465;
			5'd6:    v = 34'sd10680862;
			5'd7:    v = 34'sd5340245;
			5'd8:    v = 34'sd2670163;
			5'd9:    v = 34'sd1335087;
			5'd10:   v = 34'sd667544;
			5'd11:   v = 34'sd333772;
			5'd12:   v = 34'sd166886;
			5'd13:   v = 34'sd83443;
			5'd14:   v = 34'sd41721;
			5'd15:   v = 34'sd20860;
			5'd16:   v = 34'sd10430;
			5'd17:   v = 34'sd5215;
			5'd18:   v = 34'sd2607;
			5'd19:   v = 34'sd1303;
			default: v = '0;
		endcase
		return v;
	endfunction

	function automatic uop_t mk(input opnd_t a, input opnd_t b, input logic acc_en,
			input logic hi_split, input shift_t sh, input logic neg, input logic dacc,
			input dst_t dst);
		uop_t u;
		u.a        = a;
		u.b        = b;
		u.acc_en   = acc_en;
		u.hi_split = hi_split;
		u.sh       = sh;
		u.neg      = neg;
		u.dacc     = dacc;
		u.dst      = dst;
		return u;
	endfunction

	function automatic uop_t uop_rom(input logic [PC_W-1:0] pc);
		uop_t u;
		unique case (pc)
			6'd0:    u = mk(OP_CPS, OP_STH, 1'b0, 1'b0, SH_30, 1'b0, 1'b0, D_T);
			6'd1:    u = mk(OP_SPS, OP_STH, 1'b0, 1'b0, SH_30, 1'b0, 1'b0, D_U);
			6'd2:    u = mk(OP_CPS, OP_CTH, 1'b0, 1'b0, SH_30, 1'b0, 1'b0, D_R00);
			6'd3:    u = mk(OP_SPS, OP_CPH, 1'b0, 1'b0, SH_30, 1'b1, 1'b0, D_R01);
			6'd4:    u = mk(OP_T,   OP_SPH, 1'b0, 1'b0, SH_30, 1'b0, 1'b1, D_R01);
			6'd5:    u = mk(OP_SPS, OP_SPH, 1'b0, 1'b0, SH_30, 1'b0, 1'b0, D_R02);
			6'd6:    u = mk(OP_T,   OP_CPH, 1'b0, 1'b0, SH_30, 1'b0, 1'b1, D_R02);
			6'd7:    u = mk(OP_SPS, OP_CTH, 1'b0, 1'b0, SH_30, 1'b0, 1'b0, D_R10);
			6'd8:    u = mk(OP_CPS, OP_CPH, 1'b0, 1'b0, SH_30, 1'b0, 1'b0, D_R11);
			6'd9:    u = mk(OP_U,   OP_SPH, 1'b0, 1'b0, SH_30, 1'b0, 1'b1, D_R11);
			6'd10:   u = mk(OP_CPS, OP_SPH, 1'b0, 1'b0, SH_30, 1'b1, 1'b0, D_R12);
			6'd11:   u = mk(OP_U,   OP_CPH, 1'b0, 1'b0, SH_30, 1'b0, 1'b1, D_R12);
			6'd12:   u = mk(OP_STH, OP_ONE, 1'b0, 1'b0, SH_0,  1'b1, 1'b0, D_R20);
			6'd13:   u = mk(OP_CTH, OP_SPH, 1'b0, 1'b0, SH_30, 1'b0, 1'b0, D_R21);
			6'd14:   u = mk(OP_CTH, OP_CPH, 1'b0, 1'b0, SH_30, 1'b0, 1'b0, D_R22);
			6'd15:   u = mk(OP_AX,  OP_R00, 1'b0, 1'b0, SH_0,  1'b0, 1'b0, D_NONE);
			6'd16:   u = mk(OP_AY,  OP_R01, 1'b1, 1'b0, SH_0,  1'b0, 1'b0, D_NONE);
			6'd17:   u = mk(OP_AZ,  OP_R02, 1'b1, 1'b0, SH_30, 1'b0, 1'b0, D_AN);
			6'd18:   u = mk(OP_AX,  OP_R10, 1'b0, 1'b0, SH_0,  1'b0, 1'b0, D_NONE);
			6'd19:   u = mk(OP_AY,  OP_R11, 1'b1, 1'b0, SH_0,  1'b0, 1'b0, D_NONE);
			6'd20:   u = mk(OP_AZ,  OP_R12, 1'b1, 1'b0, SH_30, 1'b0, 1'b0, D_AE);
			6'd21:   u = mk(OP_AX,  OP_R20, 1'b0, 1'b0, SH_0,  1'b0, 1'b0, D_NONE);
			6'd22:   u = mk(OP_AY,  OP_R21, 1'b1, 1'b0, SH_0,  1'b0, 1'b0, D_NONE);
			6'd23:   u = mk(OP_AZ,  OP_R22, 1'b1, 1'b0, SH_30, 1'b0, 1'b0, D_AD);
			6'd24:   u = mk(OP_GRAV, OP_ONE, 1'b0, 1'b0, SH_0, 1'b0, 1'b1, D_AD);
			6'd25:   u = mk(OP_AN,  OP_DT,  1'b0, 1'b0, SH_24, 1'b0, 1'b1, D_VN);
			6'd26:   u = mk(OP_AE,  OP_DT,  1'b0, 1'b0, SH_24, 1'b0, 1'b1, D_VE);
			6'd27:   u = mk(OP_AD,  OP_DT,  1'b0, 1'b0, SH_24, 1'b0, 1'b1, D_VD);
			6'd28:   u = mk(OP_VNL, OP_DT,  1'b0, 1'b0, SH_0,  1'b0, 1'b0, D_NONE);
			6'd29:   u = mk(OP_VNH, OP_DT,  1'b1, 1'b1, SH_24, 1'b0, 1'b1, D_PN);
			6'd30:   u = mk(OP_VEL, OP_DT,  1'b0, 1'b0, SH_0,  1'b0, 1'b0, D_NONE);
			6'd31:   u = mk(OP_VEH, OP_DT,  1'b1, 1'b1, SH_24, 1'b0, 1'b1, D_PE);
			6'd32:   u = mk(OP_VDL, OP_DT,  1'b0, 1'b0, SH_0,  1'b0, 1'b0, D_NONE);
			6'd33:   u = mk(OP_VDH, OP_DT,  1'b1, 1'b1, SH_24, 1'b1, 1'b1, D_PU);
			default: u = mk(OP_ONE, OP_ONE, 1'b0, 1'b0, SH_0,  1'b0, 1'b0, D_NONE);
		endcase
		return u;
	endfunction

endpackage

`default_nettype wire

>>> rtl/core/sii_cordic.sv
// One CORDIC lane: sine and cosine of a binary angle in Q30.
`default_nettype none

module sii_cordic import sii_pkg::*; (
	input  logic                     clk,
	input  logic                     init,
	input  logic                     step,
	input  logic [ITER_W-1:0]        iter,
	input  logic signed [ANG_W-1:0]  angle,
	output logic signed [OPND_W-1:0] sin_val,
	output logic signed [OPND_W-1:0] cos_val
);

	logic signed [OPND_W-1:0] x_q, y_q, z_q;
	logic                     flip_q;
	logic [31:0]              turn;
	logic                     flip;
	logic signed [OPND_W-1:0] xs, ys, arc;

	assign turn = {angle, 16'd0};
	assign flip = turn[31] ^ turn[30];
	assign xs   = x_q >>> iter;
	assign ys   = y_q >>> iter;
	assign arc  = cordic_arc(iter);

	always_ff @(posedge clk) begin
		if (init) begin
			x_q    <= Q30_GAIN;
			y_q    <= '0;
			z_q    <= OPND_W'($signed({turn[31] ^ flip, turn[30:0]}));
			flip_q <= flip;
		end else if (step) begin
			if (!z_q[OPND_W-1]) begin
				x_q <= x_q - ys;
				y_q <= y_q + xs;
				z_q <= z_q - arc;
			end else begin
				x_q <= x_q + ys;
				y_q <= y_q - xs;
				z_q <= z_q + arc;
			end
		end
	end

	assign sin_val = flip_q ? -y_q : y_q;
	assign cos_val = flip_q ? -x_q : x_q;

endmodule

`default_nettype wire

>>> rtl/core/sii_datapath.sv
// Datapath: input capture, configuration, CORDIC lanes, shared multiplier and state.
`default_nettype none

module sii_datapath import sii_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  dp_cmd_t               cmd,
	input  logic [S_DATA_W-1:0]   in_data,
	input  logic                  cfg_valid,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [DT_W-1:0]       cfg_data,
	output logic [M_DATA_W-1:0]   out_data
);

	logic [DT_W-1:0]           dt_q;
	logic signed [ACCEL_W-1:0] grav_q;
	logic signed [ACCEL_W-1:0] ax_q, ay_q, az_q;
	logic signed [ANG_W-1:0]   roll_q, pitch_q, yaw_q;
	logic signed [RATE_W-1:0]  rr_q, pr_q, yr_q;
	logic signed [VEL_W-1:0]   vn_q, ve_q, vd_q;
	logic signed [POS_W-1:0]   pn_q, pe_q, pu_q;
	logic signed [OPND_W-1:0]  t_q, u_q, an_q, ae_q, ad_q;
	logic signed [OPND_W-1:0]  r00_q, r01_q, r02_q, r10_q, r11_q, r12_q, r20_q, r21_q, r22_q;
	logic signed [PROD_W-1:0]  prod_q;
	logic signed [SUM_W-1:0]   acc_q, rnd_q;
	logic signed [OPND_W-1:0]  sph, cph, sth, cth, sps, cps;
	logic signed [SUM_W-1:0]   pext, psh, sum, cur, res;

	sii_cordic u_roll (
		.clk(clk), .init(cmd.load), .step(cmd.cordic_step), .iter(cmd.iter),
		.angle(in_data[87:72]), .sin_val(sph), .cos_val(cph)
	);
	sii_cordic u_pitch (
		.clk(clk), .init(cmd.load), .step(cmd.cordic_step), .iter(cmd.iter),
		.angle(in_data[103:88]), .sin_val(sth), .cos_val(cth)
	);
	sii_cordic u_yaw (
		.clk(clk), .init(cmd.load), .step(cmd.cordic_step), .iter(cmd.iter),
		.angle(in_data[119:104]), .sin_val(sps), .cos_val(cps)
	);

	function automatic logic signed [OPND_W-1:0] pick(input opnd_t s);
		logic signed [OPND_W-1:0] v;
		unique case (s)
			OP_SPH:  v = sph;
			OP_CPH:  v = cph;
			OP_STH:  v = sth;
			OP_CTH:  v = cth;
			OP_SPS:  v = sps;
			OP_CPS:  v = cps;
			OP_AX:   v = OPND_W'(ax_q);
			OP_AY:   v = OPND_W'(ay_q);
			OP_AZ:   v = OPND_W'(az_q);
			OP_T:    v = t_q;
			OP_U:    v = u_q;
			OP_R00:  v = r00_q;
			OP_R01:  v = r01_q;
			OP_R02:  v = r02_q;
			OP_R10:  v = r10_q;
			OP_R11:  v = r11_q;
			OP_R12:  v = r12_q;
			OP_R20:  v = r20_q;
			OP_R21:  v = r21_q;
			OP_R22:  v = r22_q;
			OP_AN:   v = an_q;
			OP_AE:   v = ae_q;
			OP_AD:   v = ad_q;
			OP_GRAV: v = OPND_W'(grav_q);
			OP_DT:   v = $signed({{(OPND_W - DT_W){1'b0}}, dt_q});
			OP_ONE:  v = OPND_W'(1);
			OP_VNL:  v = $signed({{(OPND_W - SPLIT){1'b0}}, vn_q[SPLIT-1:0]});
			OP_VNH:  v = OPND_W'($signed(vn_q[VEL_W-1:SPLIT]));
			OP_VEL:  v = $signed({{(OPND_W - SPLIT){1'b0}}, ve_q[SPLIT-1:0]});
			OP_VEH:  v = OPND_W'($signed(ve_q[VEL_W-1:SPLIT]));
			OP_VDL:  v = $signed({{(OPND_W - SPLIT){1'b0}}, vd_q[SPLIT-1:0]});
			OP_VDH:  v = OPND_W'($signed(vd_q[VEL_W-1:SPLIT]));
			default: v = '0;
		endcase
		return v;
	endfunction

	function automatic logic signed [VEL_W-1:0] sat_vel(input logic signed [SUM_W-1:0] v);
		priority if (v > V_HI) return V_HI[VEL_W-1:0];
		else if (v < V_LO) return V_LO[VEL_W-1:0];
		else return v[VEL_W-1:0];
	endfunction

	function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [SUM_W-1:0] v);
		priority if (v > P_HI) return P_HI[POS_W-1:0];
		else if (v < P_LO) return P_LO[POS_W-1:0];
		else return v[POS_W-1:0];
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dt_q   <= TIME_STEP_RST;
			grav_q <= GRAVITY_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_TIME_STEP: dt_q   <= cfg_data;
				REG_GRAVITY:   grav_q <= $signed(cfg_data);
				default:       ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			ax_q    <= $signed(in_data[23:0]);
			ay_q    <= $signed(in_data[47:24]);
			az_q    <= $signed(in_data[71:48]);
			roll_q  <= $signed(in_data[87:72]);
			pitch_q <= $signed(in_data[103:88]);
			yaw_q   <= $signed(in_data[119:104]);
			rr_q    <= $signed(in_data[143:120]);
			pr_q    <= $signed(in_data[167:144]);
			yr_q    <= $signed(in_data[191:168]);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.mul) begin
			prod_q <= pick(cmd.uop.a) * pick(cmd.uop.b);
		end
	end

	assign pext = SUM_W'(prod_q);
	assign psh  = cmd.uop.hi_split ? (pext <<< SPLIT) : pext;
	assign sum  = (cmd.uop.acc_en ? acc_q : SUM_W'(0)) + psh;

	always_ff @(posedge clk) begin
		if (cmd.acc) begin
			acc_q <= sum;
			unique case (cmd.uop.sh)
				SH_24:   rnd_q <= (sum + (SUM_W'(1) <<< 23)) >>> 24;
				SH_30:   rnd_q <= (sum + (SUM_W'(1) <<< 29)) >>> 30;
				default: rnd_q <= sum;
			endcase
		end
	end

	always_comb begin
		cur = '0;
		if (cmd.uop.dacc) begin
			unique case (cmd.uop.dst)
				D_T:     cur = SUM_W'(t_q);
				D_U:     cur = SUM_W'(u_q);
				D_R00:   cur = SUM_W'(r00_q);
				D_R01:   cur = SUM_W'(r01_q);
				D_R02:   cur = SUM_W'(r02_q);
				D_R10:   cur = SUM_W'(r10_q);
				D_R11:   cur = SUM_W'(r11_q);
				D_R12:   cur = SUM_W'(r12_q);
				D_R20:   cur = SUM_W'(r20_q);
				D_R21:   cur = SUM_W'(r21_q);
				D_R22:   cur = SUM_W'(r22_q);
				D_AN:    cur = SUM_W'(an_q);
				D_AE:    cur = SUM_W'(ae_q);
				D_AD:    cur = SUM_W'(ad_q);
				D_VN:    cur = SUM_W'(vn_q);
				D_VE:    cur = SUM_W'(ve_q);
				D_VD:    cur = SUM_W'(vd_q);
				D_PN:    cur = SUM_W'(pn_q);
				D_PE:    cur = SUM_W'(pe_q);
				D_PU:    cur = SUM_W'(pu_q);
				default: cur = '0;
			endcase
		end
	end

	assign res = cmd.uop.neg ? (cur - rnd_q) : (cur + rnd_q);

	always_ff @(posedge clk) begin
		if (cmd.wr) begin
			unique case (cmd.uop.dst)
				D_T:     t_q   <= res[OPND_W-1:0];
				D_U:     u_q   <= res[OPND_W-1:0];
				D_R00:   r00_q <= res[OPND_W-1:0];
				D_R01:   r01_q <= res[OPND_W-1:0];
				D_R02:   r02_q <= res[OPND_W-1:0];
				D_R10:   r10_q <= res[OPND_W-1:0];
				D_R11:   r11_q <= res[OPND_W-1:0];
				D_R12:   r12_q <= res[OPND_W-1:0];
				D_R20:   r20_q <= res[OPND_W-1:0];
				D_R21:   r21_q <= res[OPND_W-1:0];
				D_R22:   r22_q <= res[OPND_W-1:0];
				D_AN:    an_q  <= res[OPND_W-1:0];
				D_AE:    ae_q  <= res[OPND_W-1:0];
				D_AD:    ad_q  <= res[OPND_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vn_q <= '0;
			ve_q <= '0;
			vd_q <= '0;
			pn_q <= '0;
			pe_q <= '0;
			pu_q <= '0;
		end else if (cmd.clear) begin
			vn_q <= '0;
			ve_q <= '0;
			vd_q <= '0;
			pn_q <= '0;
			pe_q <= '0;
			pu_q <= '0;
		end else if (cmd.wr) begin
			unique case (cmd.uop.dst)
				D_VN:    vn_q <= sat_vel(res);
				D_VE:    ve_q <= sat_vel(res);
				D_VD:    vd_q <= sat_vel(res);
				D_PN:    pn_q <= sat_pos(res);
				D_PE:    pe_q <= sat_pos(res);
				D_PU:    pu_q <= sat_pos(res);
				default: ;
			endcase
		end
	end

	assign out_data = {yr_q, pr_q, rr_q, yaw_q, pitch_q, roll_q,
		vd_q, ve_q, vn_q, pu_q, pe_q, pn_q};

endmodule

`default_nettype wire

>>> rtl/core/sii_ctrl.sv
// Controller: sequences CORDIC iterations and datapath operations per sample.
`default_nettype none

module sii_ctrl import sii_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	input  logic    in_cmd,
	output logic    in_ready,
	output logic    out_valid,
	input  logic    out_ready,
	output dp_cmd_t cmd
);

	typedef enum logic [5:0] {
		ST_IDLE   = 6'b000001,
		ST_CORDIC = 6'b000010,
		ST_MUL    = 6'b000100,
		ST_ACC    = 6'b001000,
		ST_WR     = 6'b010000,
		ST_OUT    = 6'b100000
	} state_t;

	localparam logic [ITER_W-1:0] ITER_LAST = ITER_W'(CORDIC_STEPS - 1);
	localparam logic [PC_W-1:0]   PC_LAST   = PC_W'(NUM_UOPS - 1);

	state_t            state_q, state_d;
	logic [ITER_W-1:0] iter_q;
	logic [PC_W-1:0]   pc_q;
	logic              accept;

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = (state_q == ST_OUT);
	assign accept    = in_valid && in_ready;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:   if (accept) state_d = in_cmd ? ST_OUT : ST_CORDIC;
			ST_CORDIC: if (iter_q == ITER_LAST) state_d = ST_MUL;
			ST_MUL:    state_d = ST_ACC;
			ST_ACC:    state_d = ST_WR;
			ST_WR:     state_d = (pc_q == PC_LAST) ? ST_OUT : ST_MUL;
			ST_OUT:    if (out_ready) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			iter_q  <= '0;
			pc_q    <= '0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				iter_q <= '0;
				pc_q   <= '0;
			end else begin
				if (state_q == ST_CORDIC) iter_q <= iter_q + ITER_W'(1);
				if (state_q == ST_WR) pc_q <= pc_q + PC_W'(1);
			end
		end
	end

	always_comb begin
		cmd.load        = accept;
		cmd.clear       = accept && in_cmd;
		cmd.cordic_step = (state_q == ST_CORDIC);
		cmd.iter        = iter_q;
		cmd.mul         = (state_q == ST_MUL);
		cmd.acc         = (state_q == ST_ACC);
		cmd.wr          = (state_q == ST_WR);
		cmd.uop         = uop_rom(pc_q);
	end

`ifndef NO_ASSERTIONS
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid))
		else $error("input and output sides open together");
	a_clear_direct: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && in_cmd) |=> (state_q == ST_OUT))
		else $error("clear did not go straight to output");
	a_start_cordic: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && !in_cmd) |=> (state_q == ST_CORDIC && iter_q == '0))
		else $error("sample did not start CORDIC at iteration zero");
	a_last_op: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WR && pc_q == PC_LAST) |=> (state_q == ST_OUT))
		else $error("last operation did not present result");
	a_iter_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CORDIC) |-> (iter_q <= ITER_LAST))
		else $error("CORDIC iteration out of range");
`endif

endmodule

`default_nettype wire

>>> rtl/core/strapdown_inertial_integrator_top.sv
// Top level of the strapdown inertial integrator.
// Usage:
// - Slave stream (s_*) takes one IMU sample per transfer; s_tuser is the clear
//   command, s_tdata the acceleration, attitude and rates.
// - Master stream (m_*) returns one result per sample: position, velocity and
//   the copied attitude and rates.
// - Config channel (cfg_*) writes time_step (index 0) or gravity_offset
//   (index 1); other indexes are dropped. cfg_ready is always high.
// - Sequencing: an integrate sample takes 20 CORDIC iterations, then 34
//   operations (multiply, accumulate, write) on the shared multiplier,
//   before m_tvalid; a clear sample shows m_tvalid in the cycle after.
// - Flow: one sample at a time; s_tready returns in the cycle after the
//   result transfer.
// - Reset clears velocity, position and the controller, and loads default
//   configuration. A stalled receiver holds m_tvalid and m_tdata and keeps
//   s_tready low until the result transfers.
`default_nettype none

module strapdown_inertial_integrator_top import sii_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	// accel_x, accel_y, accel_z, roll_angle, pitch_angle, yaw_angle,
	// roll_rate_in, pitch_rate_in, yaw_rate_in
	input  logic [S_DATA_W-1:0]  s_tdata,
	// cmd
	input  logic                 s_tuser,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	// pos_north, pos_east, pos_up, vel_north_out, vel_east_out, vel_down_out,
	// roll_out, pitch_out, yaw_out, roll_rate_out, pitch_rate_out, yaw_rate_out
	output logic [M_DATA_W-1:0]  m_tdata,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [DT_W-1:0]      cfg_data
);

	dp_cmd_t cmd;

	assign cfg_ready = 1'b1;

	sii_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_cmd    (s_tuser),
		.in_ready  (s_tready),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.cmd       (cmd)
	);

	sii_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.in_data   (s_tdata),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.out_data  (m_tdata)
	);

endmodule

`default_nettype wire

>>> bench/strapdown_inertial_integrator_top_tb.sv
// Self-checking testbench for the strapdown inertial integrator stream top level.
`default_nettype none

module strapdown_inertial_integrator_top_tb import sii_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int IDLE_LIMIT = 5000;
	localparam int HOLD_CYCLES = 1500;
	localparam int PHASE_ITEMS = 155;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;
	localparam int FOFS[12] = '{0, 48, 96, 144, 184, 224, 264, 280, 296, 312, 336, 360};
	localparam int FW[12] = '{48, 48, 48, 40, 40, 40, 16, 16, 16, 24, 24, 24};
	localparam string FNAME[12] = '{"pos_north", "pos_east", "pos_up", "vel_north_out",
		"vel_east_out", "vel_down_out", "roll_out", "pitch_out", "yaw_out",
		"roll_rate_out", "pitch_rate_out", "yaw_rate_out"};
	localparam longint ARC[20] = '{536870912, 316933406, 167458907, 85004756, 42667331,
		21354465, 10680862, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
		41721, 20860, 10430, 5215, 2607, 1303};

	class ins_scoreboard;
		logic [DT_W-1:0] step;
		longint grav;
		longint vn, ve, vd, pn, pe, pu;
		logic [M_DATA_W-1:0] pending_q[$];
		int fails;

		function new();
			step = TIME_STEP_RST;
			grav = longint'(GRAVITY_RST);
			vn = 0; ve = 0; vd = 0; pn = 0; pe = 0; pu = 0;
			fails = 0;
		endfunction

		function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [DT_W-1:0] v);
			if (idx == REG_TIME_STEP) begin
				step = v;
			end else if (idx == REG_GRAVITY) begin
				grav = longint'($signed(v));
			end
		endfunction

		function longint rnd(longint v, int s);
			return (v + (64'sd1 <<< (s - 1))) >>> s;
		endfunction

		function longint clip(longint v, longint lo, longint hi);
			return v < lo ? lo : (v > hi ? hi : v);
		endfunction

		function void sincos(logic [ANG_W-1:0] a, output longint s, output longint c);
			logic [31:0] u;
			logic flip;
			longint x, y, z, nx;
			u = {a, 16'h0000};
			flip = (u[31:30] == 2'd1) || (u[31:30] == 2'd2);
			if (flip) u = u + 32'h8000_0000;
			z = longint'($signed(u));
			x = longint'(Q30_GAIN);
			y = 0;
			for (int i = 0; i < 20; i++) begin
				if (z >= 0) begin
					nx = x - (y >>> i);
					y = y + (x >>> i);
					z -= ARC[i];
				end else begin
					nx = x + (y >>> i);
					y = y - (x >>> i);
					z += ARC[i];
				end
				x = nx;
			end
			if (flip) begin
				x = -x;
				y = -y;
			end
			s = y;
			c = x;
		endfunction

		function void note_sample(logic clr, logic [S_DATA_W-1:0] d);
			longint ax, ay, az, sph, cph, sth, cth, sps, cps, an, ae, ad, dt, vmax, pmax;
			ax = longint'($signed(d[23:0]));
			ay = longint'($signed(d[47:24]));
			az = longint'($signed(d[71:48]));
			dt = longint'({40'd0, step});
			vmax = (64'sd1 <<< (VEL_W - 1)) - 1;
			pmax = (64'sd1 <<< (POS_W - 1)) - 1;
			if (clr) begin
				vn = 0; ve = 0; vd = 0; pn = 0; pe = 0; pu = 0;
			end else begin
				sincos(d[87:72], sph, cph);
				sincos(d[103:88], sth, cth);
				sincos(d[119:104], sps, cps);
				an = rnd(ax * rnd(cps * cth, 30)
					+ ay * (-rnd(sps * cph, 30) + rnd(rnd(cps * sth, 30) * sph, 30))
					+ az * (rnd(sps * sph, 30) + rnd(rnd(cps * sth, 30) * cph, 30)), 30);
				ae = rnd(ax * rnd(sps * cth, 30)
					+ ay * (rnd(cps * cph, 30) + rnd(rnd(sps * sth, 30) * sph, 30))
					+ az * (-rnd(cps * sph, 30) + rnd(rnd(sps * sth, 30) * cph, 30)), 30);
				ad = rnd(ax * (-sth) + ay * rnd(cth * sph, 30) + az * rnd(cth * cph, 30), 30)
					+ grav;
				vn = clip(vn + rnd(an * dt, 24), -vmax - 1, vmax);
				ve = clip(ve + rnd(ae * dt, 24), -vmax - 1, vmax);
				vd = clip(vd + rnd(ad * dt, 24), -vmax - 1, vmax);
				pn = clip(pn + rnd(vn * dt, 24), -pmax - 1, pmax);
				pe = clip(pe + rnd(ve * dt, 24), -pmax - 1, pmax);
				pu = clip(pu - rnd(vd * dt, 24), -pmax - 1, pmax);
			end
			pending_q.push_back({d[191:120], d[119:72], vd[39:0], ve[39:0], vn[39:0],
				pu[47:0], pe[47:0], pn[47:0]});
		endfunction

		function void check_result(logic [M_DATA_W-1:0] got);
			logic [M_DATA_W-1:0] want, m;
			if (pending_q.size() == 0) begin
				$display("%0t unexpected result %h", $time, got);
				fails++;
				return;
			end
			want = pending_q.pop_front();
			for (int i = 0; i < 12; i++) begin
				m = (384'd1 << FW[i]) - 384'd1;
				if (((want >> FOFS[i]) & m) != ((got >> FOFS[i]) & m)) begin
					$display("%0t %s expected %h got %h", $time, FNAME[i],
						(want >> FOFS[i]) & m, (got >> FOFS[i]) & m);
					fails++;
				end
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic s_tvalid, s_tready, s_tuser;
	logic [S_DATA_W-1:0] s_tdata;
	logic m_tvalid, m_tready;
	logic [M_DATA_W-1:0] m_tdata;
	logic cfg_valid, cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [DT_W-1:0] cfg_data;

	ins_scoreboard sb;
	bit hold_req;
	bit rx_quiet, tx_quiet;
	int idle_cycles;

	strapdown_inertial_integrator_top dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		clk = 1'b1;
		#4;
		clk = 1'b0;
		#4;
	end

	function automatic logic [S_DATA_W-1:0] pack_sample(logic [23:0] ax, ay, az,
			logic [15:0] r, p, y, logic [23:0] wr, wp, wy);
		return {wy, wp, wr, y, p, r, az, ay, ax};
	endfunction

	function automatic logic [23:0] pick24();
		case ($urandom_range(0, 9))
			0: return 24'h800000;
			1: return 24'h7FFFFF;
			2: return 24'h000000;
			3: return 24'($signed($urandom_range(0, 2000)) - 1000);
			default: return 24'($urandom);
		endcase
	endfunction

	function automatic logic [S_DATA_W-1:0] rand_sample();
		return pack_sample(pick24(), pick24(), pick24(), 16'($urandom), 16'($urandom),
			16'($urandom), 24'($urandom), 24'($urandom), 24'($urandom));
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (tx_quiet || r < 60) return 0;
		if (r < 90) return $urandom_range(1, 4);
		if (r < 98) return $urandom_range(5, 20);
		return $urandom_range(50, 300);
	endfunction

	task automatic send_sample(logic clr, logic [S_DATA_W-1:0] d);
		int gap;
		gap = pick_gap();
		s_tvalid <= 1'b1;
		s_tuser <= clr;
		s_tdata <= d;
		do @(posedge clk); while (!s_tready);
		sb.note_sample(clr, d);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (sb.pending_q.size() != 0) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [DT_W-1:0] v);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		sb.set_reg(idx, v);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) sb.check_result(m_tdata);
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("strapdown_inertial_integrator_top_tb failed");
				$finish;
			end
		end
	end

	initial begin : receiver
		int r;
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_req) begin
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_req = 1'b0;
			end else if (rx_quiet) begin
				m_tready <= 1'b1;
			end else begin
				r = $urandom_range(0, 99);
				if (r < 3) begin
					m_tready <= 1'b0;
					repeat ($urandom_range(20, 150)) @(posedge clk);
				end else begin
					m_tready <= (r < 75);
				end
			end
		end
	end

	initial begin : stimulus
		logic [23:0] ts, gv;
		sb = new();
		idle_cycles = 0;
		hold_req = 1'b0;
		rx_quiet = 1'b0;
		tx_quiet = 1'b0;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tuser = 1'b0;
		s_tdata = '0;
		cfg_valid = 1'b0;
		cfg_index = REG_TIME_STEP;
		cfg_data = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_sample(1'b0, '0);
		send_sample(1'b0, pack_sample(24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 16'h7FFF,
			16'h7FFF, 16'h7FFF, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF));
		send_sample(1'b0, pack_sample(24'h800000, 24'h800000, 24'h800000, 16'h8000,
			16'h8000, 16'h8000, 24'h800000, 24'h800000, 24'h800000));
		send_sample(1'b0, pack_sample(24'h010000, 24'h0, 24'h0, 16'h4000, 16'h0, 16'h0,
			24'h1, 24'h2, 24'h3));
		send_sample(1'b0, pack_sample(24'h0, 24'h010000, 24'h0, 16'h0, 16'h4000, 16'hC000,
			24'h0, 24'h0, 24'h0));
		send_sample(1'b0, pack_sample(24'h0, 24'h0, 24'h09CF5C, 16'hC000, 16'hC000,
			16'h4000, 24'h0, 24'h0, 24'h0));
		send_sample(1'b1, pack_sample(24'h123456, 24'hABCDEF, 24'h7FFFFF, 16'h1234,
			16'h8000, 16'h7FFF, 24'hFFFFFF, 24'h0, 24'h555555));
		send_sample(1'b0, pack_sample(24'h7FFFFF, 24'h800000, 24'h7FFFFF, 16'h2000,
			16'hE000, 16'h6000, 24'h0, 24'hFFFFFF, 24'h0));
		send_sample(1'b1, '0);
		repeat (6) send_sample(1'b0, rand_sample());

		drain();
		write_reg(REG_SPARE_A, 24'hFFFFFF);
		write_reg(REG_SPARE_B, 24'h000001);
		write_reg(REG_TIME_STEP, 24'd0);
		repeat (5) send_sample(1'b0, rand_sample());

		for (int ph = 0; ph < 6; ph++) begin
			drain();
			case (ph)
				0: begin ts = 24'hFFFFFF; gv = 24'h7FFFFF; end
				1: begin ts = 24'd1; gv = 24'h800000; end
				2: begin ts = TIME_STEP_RST; gv = GRAVITY_RST; end
				default: begin ts = 24'($urandom_range(1, 24'hFFFFFF)); gv = 24'($urandom); end
			endcase
			write_reg(REG_TIME_STEP, ts);
			write_reg(REG_GRAVITY, gv);
			rx_quiet = (ph == 4);
			tx_quiet = (ph == 4);
			if (ph == 2) hold_req = 1'b1;
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if (ph == 3 && n == PHASE_ITEMS / 2) drain();
				send_sample($urandom_range(0, 19) == 0, rand_sample());
			end
		end

		drain();
		repeat (130) @(posedge clk);
		if (sb.fails == 0 && sb.pending_q.size() == 0) begin
			$display("strapdown_inertial_integrator_top_tb passed");
		end else begin
			$display("strapdown_inertial_integrator_top_tb failed");
		end
		$finish;
	end

endmodule

`default_nettype wire

>>> files.f
rtl/core/sii_pkg.sv
rtl/core/sii_cordic.sv
rtl/core/sii_datapath.sv
rtl/core/sii_ctrl.sv
rtl/core/strapdown_inertial_integrator_top.sv
bench/strapdown_inertial_integrator_top_tb.sv
